// File: rtl/rti_pkg.sv
`timescale 1ns / 1ps
package rti_pkg;

	localparam int unsigned CRD_W  = 32;
	localparam int unsigned NUM_REGS = 6;
	localparam int unsigned IDX_W  = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_DIR_X    = 3'd3,
		REG_DIR_Y    = 3'd4,
		REG_DIR_Z    = 3'd5
	} reg_idx_t;

	localparam logic signed [CRD_W-1:0] DIR_Z_RST = -32'sd65536;

	typedef struct packed {
		logic signed [CRD_W-1:0] v0_x;
		logic signed [CRD_W-1:0] v0_y;
		logic signed [CRD_W-1:0] v0_z;
		logic signed [CRD_W-1:0] v1_x;
		logic signed [CRD_W-1:0] v1_y;
		logic signed [CRD_W-1:0] v1_z;
		logic signed [CRD_W-1:0] v2_x;
		logic signed [CRD_W-1:0] v2_y;
		logic signed [CRD_W-1:0] v2_z;
	} tri_item_t;

	typedef struct packed {
		logic hit;
	} hit_item_t;

endpackage

// File: rtl/rti_stream_if.sv
`timescale 1ns / 1ps
interface rti_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/rti_cfg_if.sv
`timescale 1ns / 1ps
interface rti_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: rtl/ray_triangle_intersect_core.sv
`timescale 1ns / 1ps
// Ray / triangle hit test, one triangle per transaction against a ray held
// in six config registers (origin x/y/z, direction x/y/z, Q16.16).
// Channels: triangle (sink, nine vertex coordinates), result (source, hit
// bit), cfg (sink, register index and 32-bit data; always ready, writes
// to indexes beyond the list are dropped). Write config only while idle.
// Pipeline: seven register stages; result.valid is the last stage's valid.
// Throughput: one triangle per cycle when not stalled; each stage holds
// at most one rank of 33x35-bit multipliers or a short chain of 106-bit
// adds and a compare.
// Stall: when result is valid and not taken, the whole pipeline freezes
// and triangle.ready drops, bubbles included; nothing is lost or repeated.
// Reset (arst_n low, async): pipeline emptied, origin 0, direction
// (0,0,-1). Hit is exact: zero det gives no hit, edges count as hits,
// and the ray distance is not checked.
module ray_triangle_intersect_core (
	input  logic             clk,
	input  logic             arst_n,
	rti_stream_if.sink       triangle,
	rti_stream_if.source     result,
	rti_cfg_if.sink          cfg
);
	import rti_pkg::*;

	localparam int unsigned E_W  = CRD_W + 1;
	localparam int unsigned M_W  = 2 * E_W;
	localparam int unsigned V_W  = M_W + 1;
	localparam int unsigned LO_W = V_W - E_W;
	localparam int unsigned PL_W = LO_W + 1 + E_W;
	localparam int unsigned A_W  = 106;

	logic signed [CRD_W-1:0] org_q [3];
	logic signed [CRD_W-1:0] dir_q [3];

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;

	logic signed [E_W-1:0] e1_s1 [3], e2_s1 [3], t_s1 [3];
	logic signed [M_W-1:0] pp_s2 [6], qp_s2 [6];
	logic signed [E_W-1:0] e1_s2 [3], t_s2 [3];
	logic signed [V_W-1:0] p_s3 [3], q_s3 [3];
	logic signed [E_W-1:0] e1_s3 [3], t_s3 [3];
	logic signed [M_W-1:0]  hd_s4 [3], hu_s4 [3], hv_s4 [3];
	logic signed [PL_W-1:0] ld_s4 [3], lu_s4 [3], lv_s4 [3];
	logic signed [A_W-1:0] td_s5 [3], tu_s5 [3], tv_s5 [3];
	logic signed [A_W-1:0] det_s6, pu_s6, qv_s6;
	logic hit_s7;

	logic signed [E_W-1:0] d_e [3];
	logic signed [E_W-1:0] e1_c [3], e2_c [3], t_c [3];
	logic signed [M_W-1:0] pp_c [6], qp_c [6];
	logic signed [V_W-1:0] p_c [3], q_c [3];
	logic signed [M_W-1:0]  hd_c [3], hu_c [3], hv_c [3];
	logic signed [PL_W-1:0] ld_c [3], lu_c [3], lv_c [3];
	logic signed [A_W-1:0] td_c [3], tu_c [3], tv_c [3];
	logic signed [A_W-1:0] det_c, pu_c, qv_c;
	logic hit_c;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q[0] <= '0;
			org_q[1] <= '0;
			org_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= '0;
			dir_q[2] <= DIR_Z_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_ORIGIN_X: org_q[0] <= cfg.wdata;
				REG_ORIGIN_Y: org_q[1] <= cfg.wdata;
				REG_ORIGIN_Z: org_q[2] <= cfg.wdata;
				REG_DIR_X:    dir_q[0] <= cfg.wdata;
				REG_DIR_Y:    dir_q[1] <= cfg.wdata;
				REG_DIR_Z:    dir_q[2] <= cfg.wdata;
				default: ;
			endcase
		end
	end

	assign en             = !vld_s7 || result.ready;
	assign triangle.ready = en;
	assign result.valid   = vld_s7;
	assign result.data.hit = hit_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s1 <= triangle.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	// edges and origin offset
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_e[i] = E_W'(dir_q[i]);
		end
		e1_c[0] = E_W'(triangle.data.v1_x) - E_W'(triangle.data.v0_x);
		e1_c[1] = E_W'(triangle.data.v1_y) - E_W'(triangle.data.v0_y);
		e1_c[2] = E_W'(triangle.data.v1_z) - E_W'(triangle.data.v0_z);
		e2_c[0] = E_W'(triangle.data.v2_x) - E_W'(triangle.data.v0_x);
		e2_c[1] = E_W'(triangle.data.v2_y) - E_W'(triangle.data.v0_y);
		e2_c[2] = E_W'(triangle.data.v2_z) - E_W'(triangle.data.v0_z);
		t_c[0]  = E_W'(org_q[0]) - E_W'(triangle.data.v0_x);
		t_c[1]  = E_W'(org_q[1]) - E_W'(triangle.data.v0_y);
		t_c[2]  = E_W'(org_q[2]) - E_W'(triangle.data.v0_z);
	end

	// cross products: P = D x E2, Q = T x E1
	always_comb begin
		pp_c[0] = d_e[1] * e2_s1[2];
		pp_c[1] = d_e[2] * e2_s1[1];
		pp_c[2] = d_e[2] * e2_s1[0];
		pp_c[3] = d_e[0] * e2_s1[2];
		pp_c[4] = d_e[0] * e2_s1[1];
		pp_c[5] = d_e[1] * e2_s1[0];
		qp_c[0] = t_s1[1] * e1_s1[2];
		qp_c[1] = t_s1[2] * e1_s1[1];
		qp_c[2] = t_s1[2] * e1_s1[0];
		qp_c[3] = t_s1[0] * e1_s1[2];
		qp_c[4] = t_s1[0] * e1_s1[1];
		qp_c[5] = t_s1[1] * e1_s1[0];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i] = V_W'(pp_s2[2*i]) - V_W'(pp_s2[2*i+1]);
			q_c[i] = V_W'(qp_s2[2*i]) - V_W'(qp_s2[2*i+1]);
		end
	end

	// dot products split into high and low partial products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			hd_c[i] = $signed(p_s3[i][V_W-1:LO_W]) * e1_s3[i];
			hu_c[i] = $signed(p_s3[i][V_W-1:LO_W]) * t_s3[i];
			hv_c[i] = $signed(q_s3[i][V_W-1:LO_W]) * d_e[i];
			ld_c[i] = $signed({1'b0, p_s3[i][LO_W-1:0]}) * e1_s3[i];
			lu_c[i] = $signed({1'b0, p_s3[i][LO_W-1:0]}) * t_s3[i];
			lv_c[i] = $signed({1'b0, q_s3[i][LO_W-1:0]}) * d_e[i];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			td_c[i] = (A_W'(hd_s4[i]) <<< LO_W) + A_W'(ld_s4[i]);
			tu_c[i] = (A_W'(hu_s4[i]) <<< LO_W) + A_W'(lu_s4[i]);
			tv_c[i] = (A_W'(hv_s4[i]) <<< LO_W) + A_W'(lv_s4[i]);
		end
		det_c = td_s5[0] + td_s5[1] + td_s5[2];
		pu_c  = tu_s5[0] + tu_s5[1] + tu_s5[2];
		qv_c  = tv_s5[0] + tv_s5[1] + tv_s5[2];
	end

	// exact barycentric test, signs folded by det
	always_comb begin
		logic signed [A_W:0] a_det, a_pu, a_qv, a_sum;
		if (det_s6[A_W-1]) begin
			a_det = -(A_W+1)'(det_s6);
			a_pu  = -(A_W+1)'(pu_s6);
			a_qv  = -(A_W+1)'(qv_s6);
		end else begin
			a_det = (A_W+1)'(det_s6);
			a_pu  = (A_W+1)'(pu_s6);
			a_qv  = (A_W+1)'(qv_s6);
		end
		a_sum = a_pu + a_qv;
		hit_c = (det_s6 != '0) && !a_pu[A_W] && !a_qv[A_W] && (a_sum <= a_det);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e1_s1 <= e1_c;
			e2_s1 <= e2_c;
			t_s1  <= t_c;
			pp_s2 <= pp_c;
			qp_s2 <= qp_c;
			e1_s2 <= e1_s1;
			t_s2  <= t_s1;
			p_s3  <= p_c;
			q_s3  <= q_c;
			e1_s3 <= e1_s2;
			t_s3  <= t_s2;
			hd_s4 <= hd_c;
			hu_s4 <= hu_c;
			hv_s4 <= hv_c;
			ld_s4 <= ld_c;
			lu_s4 <= lu_c;
			lv_s4 <= lv_c;
			td_s5 <= td_c;
			tu_s5 <= tu_c;
			tv_s5 <= tv_c;
			det_s6 <= det_c;
			pu_s6  <= pu_c;
			qv_s6  <= qv_c;
			hit_s7 <= hit_c;
		end
	end

`ifndef NO_ASSERTIONS
	a_zero_det: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 && en && det_s6 == '0 |=> !hit_s7)
		else $error("hit reported with zero det");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !result.ready |=>
		$stable({vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6}))
		else $error("pipeline moved during stall");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		triangle.valid && triangle.ready |=> vld_s1)
		else $error("accepted transaction not in first stage");
`endif

endmodule

// File: tb/sv/tb_rti_checker.sv
`timescale 1ns / 1ps
module tb_rti_checker
	import rti_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      tri_valid,
	input  logic      tri_ready,
	input  tri_item_t tri_data,
	input  logic      res_valid,
	input  logic      res_ready,
	input  hit_item_t res_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	output int        fail_count,
	output int        pending_hits,
	output int        hits_seen,
	output int        results_seen
);
	typedef logic signed [127:0] wide_t;

	logic signed [31:0] ray_reg [NUM_REGS];
	logic hit_queue [$];

	function automatic logic predict_hit(tri_item_t t);
		wide_t o [3];
		wide_t d [3];
		wide_t v0 [3];
		wide_t e1 [3];
		wide_t e2 [3];
		wide_t tv [3];
		wide_t p [3];
		wide_t q [3];
		wide_t det, pu, qv;
		o[0] = ray_reg[REG_ORIGIN_X];
		o[1] = ray_reg[REG_ORIGIN_Y];
		o[2] = ray_reg[REG_ORIGIN_Z];
		d[0] = ray_reg[REG_DIR_X];
		d[1] = ray_reg[REG_DIR_Y];
		d[2] = ray_reg[REG_DIR_Z];
		v0[0] = t.v0_x; v0[1] = t.v0_y; v0[2] = t.v0_z;
		e1[0] = wide_t'(t.v1_x) - v0[0];
		e1[1] = wide_t'(t.v1_y) - v0[1];
		e1[2] = wide_t'(t.v1_z) - v0[2];
		e2[0] = wide_t'(t.v2_x) - v0[0];
		e2[1] = wide_t'(t.v2_y) - v0[1];
		e2[2] = wide_t'(t.v2_z) - v0[2];
		for (int i = 0; i < 3; i++)
			tv[i] = o[i] - v0[i];
		p[0] = d[1] * e2[2] - d[2] * e2[1];
		p[1] = d[2] * e2[0] - d[0] * e2[2];
		p[2] = d[0] * e2[1] - d[1] * e2[0];
		q[0] = tv[1] * e1[2] - tv[2] * e1[1];
		q[1] = tv[2] * e1[0] - tv[0] * e1[2];
		q[2] = tv[0] * e1[1] - tv[1] * e1[0];
		det = p[0] * e1[0] + p[1] * e1[1] + p[2] * e1[2];
		pu = p[0] * tv[0] + p[1] * tv[1] + p[2] * tv[2];
		qv = q[0] * d[0] + q[1] * d[1] + q[2] * d[2];
		if (det == 0)
			return 1'b0;
		if (det < 0) begin
			det = -det; pu = -pu; qv = -qv;
		end
		return pu >= 0 && qv >= 0 && det - (pu + qv) >= 0;
	endfunction

	assign pending_hits = hit_queue.size();

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				ray_reg[i] <= (i == REG_DIR_Z) ? DIR_Z_RST : '0;
			hit_queue.delete();
			fail_count <= 0;
			hits_seen <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS)
				ray_reg[cfg_index] <= cfg_wdata;
			if (tri_valid && tri_ready)
				hit_queue.push_back(predict_hit(tri_data));
			if (res_valid && res_ready) begin
				results_seen <= results_seen + 1;
				hits_seen <= hits_seen + res_data.hit;
				if (hit_queue.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result hit=%0b", res_data.hit);
					fail_count <= fail_count + 1;
				end else begin
					if (hit_queue[0] !== res_data.hit) begin
						if (fail_count < 10)
							$display("hit mismatch: expected %0b got %0b",
								hit_queue[0], res_data.hit);
						fail_count <= fail_count + 1;
					end
					hit_queue.pop_front();
				end
			end
		end
	end
endmodule

// File: tb/sv/tb_ray_triangle_intersect_core.sv
`timescale 1ns / 1ps
module tb_ray_triangle_intersect_core;
	import rti_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count, pending_hits, hits_seen, results_seen;
	int   cycle = 0;
	bit   no_idle = 0;
	bit   hold_off = 0;
	int   directed_left;

	rti_stream_if #(.T(tri_item_t)) triangle ();
	rti_stream_if #(.T(hit_item_t)) result ();
	rti_cfg_if cfg ();

	ray_triangle_intersect_core dut (
		.clk(clk), .arst_n(arst_n),
		.triangle(triangle.sink), .result(result.source), .cfg(cfg.sink)
	);

	tb_rti_checker chk (
		.clk(clk), .arst_n(arst_n),
		.tri_valid(triangle.valid), .tri_ready(triangle.ready), .tri_data(triangle.data),
		.res_valid(result.valid), .res_ready(result.ready), .res_data(result.data),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
		.cfg_index(cfg.index), .cfg_wdata(cfg.wdata),
		.fail_count(fail_count), .pending_hits(pending_hits),
		.hits_seen(hits_seen), .results_seen(results_seen)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 400000) begin
			$display("timeout");
			$display("tb_ray_triangle_intersect_core: FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off
	initial begin
		int n;
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off) begin
				result.ready <= 0;
				for (int i = 0; i < 60; i++)
					@(negedge clk);
				hold_off = 0;
			end else if (!no_idle && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 5);
				result.ready <= 0;
				for (int i = 1; i < n; i++)
					@(negedge clk);
			end else
				result.ready <= 1;
		end
	end

	function automatic logic signed [31:0] rand_crd(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 8)) * 32'sh10000 - 32'sh40000;
			2: return $signed($urandom_range(0, 2000)) * 32'sd256 - 32'sd256000;
			default: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	task automatic send_tri(tri_item_t t);
		int n;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			triangle.valid <= 0;
			n = $urandom_range(1, 5);
			repeat (n) @(negedge clk);
		end
		triangle.data <= t;
		triangle.valid <= 1;
		do @(posedge clk); while (!triangle.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		triangle.valid <= 0;
		while (pending_hits != 0) @(negedge clk);
		repeat (12) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg.index <= idx;
		cfg.wdata <= val;
		cfg.valid <= 1;
		do @(posedge clk); while (!cfg.ready);
		@(negedge clk);
		cfg.valid <= 0;
		@(negedge clk);
	endtask

	// ray whose line crosses near the small triangles used below
	task automatic set_ray(int mode);
		for (int r = 0; r < NUM_REGS; r++)
			write_reg(r[2:0], (mode == 0) ? rand_crd(r < 3 ? 1 : 2) : rand_crd(mode));
	endtask

	function automatic tri_item_t rand_tri(int mode);
		tri_item_t t;
		t = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		if (mode != 0) begin
			t.v0_x = rand_crd(mode); t.v0_y = rand_crd(mode); t.v0_z = rand_crd(mode);
			t.v1_x = rand_crd(mode); t.v1_y = rand_crd(mode); t.v1_z = rand_crd(mode);
			t.v2_x = rand_crd(mode); t.v2_y = rand_crd(mode); t.v2_z = rand_crd(mode);
		end
		return t;
	endfunction

	initial begin
		tri_item_t t;
		int m;
		triangle.valid = 0;
		triangle.data = '0;
		cfg.valid = 0;
		cfg.index = '0;
		cfg.wdata = '0;
		repeat (9) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// default ray (0,0,0)->(0,0,-1): inside, edge, vertex, outside, degenerate
		t = '0;
		t.v0_x = -32'sh10000; t.v0_y = -32'sh10000;
		t.v1_x = 32'sh10000; t.v1_y = -32'sh10000;
		t.v2_y = 32'sh10000;
		send_tri(t);
		t.v0_z = 32'sh50000; t.v1_z = 32'sh50000; t.v2_z = 32'sh50000;
		send_tri(t);
		t = '0; t.v1_x = 32'sh10000; t.v2_y = 32'sh10000;
		send_tri(t);
		t.v0_x = -32'sh10000;
		send_tri(t);
		t = '0; t.v0_x = 32'sh10000; t.v1_x = 32'sh20000; t.v2_x = 32'sh30000;
		send_tri(t);
		t = '0; t.v0_x = 32'sh10000; t.v1_x = 32'sh20000; t.v2_y = 32'sh10000;
		send_tri(t);
		t = '0; t.v1_x = 32'sh10000; t.v2_z = 32'sh10000;
		send_tri(t);
		t = '1; send_tri(t);
		t = {9{32'h80000000}}; send_tri(t);
		t = {9{32'h7fffffff}}; send_tri(t);
		t = {32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000};
		send_tri(t);
		drain();
		// zero direction, then extreme rays
		for (int r = 0; r < NUM_REGS; r++) write_reg(r[2:0], 32'h0);
		write_reg(3'd6, 32'hffffffff);
		for (int i = 0; i < 3; i++) send_tri(rand_tri(1));
		drain();
		for (int r = 0; r < NUM_REGS; r++) write_reg(r[2:0], 32'h7fffffff);
		for (int i = 0; i < 4; i++) send_tri(rand_tri(3));
		drain();
		for (int r = 0; r < NUM_REGS; r++) write_reg(r[2:0], 32'h80000000);
		for (int i = 0; i < 4; i++) send_tri(rand_tri(3));
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			m = $urandom_range(0, 3);
			set_ray(m == 3 ? 0 : m);
			if (ph == 11) no_idle = 1;
			if (ph == 2) hold_off = 1;
			for (int i = 0; i < 95; i++)
				send_tri(rand_tri(m == 3 ? 1 : ((i % 7 == 0) ? $urandom_range(0, 3) : 1)));
			drain();
		end

		$display("ran %0d triangles over directed and 12 random rays, %0d hits seen",
			results_seen, hits_seen);
		if (fail_count == 0 && pending_hits == 0)
			$display("tb_ray_triangle_intersect_core: PASS");
		else
			$display("tb_ray_triangle_intersect_core: FAIL");
		$finish;
	end
endmodule

// File: files.f
rtl/rti_pkg.sv
rtl/rti_stream_if.sv
rtl/rti_cfg_if.sv
rtl/ray_triangle_intersect_core.sv
tb/sv/tb_rti_checker.sv
tb/sv/tb_ray_triangle_intersect_core.sv
